@@ rtl/core/assert_macros.svh @@
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define NNTB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define NNTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/nntb_pkg.sv @@
// types and constants of the nearest neighbor tour builder
package nntb_pkg;

  localparam int VERTEX_W    = 4;
  localparam int WEIGHT_IN_W = 16;
  localparam int TOTAL_W     = 21;
  localparam int VC_W        = 5;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [VC_W-1:0]    VC_RESET  = VC_W'(16);
  localparam logic [VC_W-1:0]    VC_MIN    = VC_W'(2);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_RUN  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                   command;
    logic [VERTEX_W-1:0]    row;
    logic [VERTEX_W-1:0]    col;
    logic [WEIGHT_IN_W-1:0] weight;
  } cmd_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [TOTAL_W-1:0]  total_cost;
    logic                last;
  } res_t;

  // one classified command waiting for the back end
  typedef struct packed {
    cmd_e                   op;
    logic                   in_range;
    logic [VERTEX_W-1:0]    row;
    logic [VERTEX_W-1:0]    col;
    logic [WEIGHT_IN_W-1:0] weight;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } queue_if_t;

endpackage

@@ rtl/core/nntb_front.sv @@
// front end: accepts commands, classifies them and queues them for the back end
module nntb_front #(
  parameter int MAX_VERTICES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  nntb_pkg::cmd_t     cmd_i,
  input  logic               pop_i,
  output nntb_pkg::queue_if_t q_o
);
  import nntb_pkg::*;

  q_item_t    fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;
  q_item_t    item_in;

  assign busy = (count_q == 2'd2);
  assign push = start && !busy;
  assign pop  = pop_i && (count_q != 2'd0);

  always_comb begin
    item_in.op       = cmd_e'(cmd_i.command);
    item_in.in_range = (32'(cmd_i.row) < MAX_VERTICES) && (32'(cmd_i.col) < MAX_VERTICES);
    item_in.row      = cmd_i.row;
    item_in.col      = cmd_i.col;
    item_in.weight   = cmd_i.weight;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

  assign q_o.valid = (count_q != 2'd0);
  assign q_o.item  = fifo_q[rd_ptr_q];

endmodule

@@ rtl/core/nntb_back.sv @@
// back end: cost matrix memory, tour sequencer and result register
module nntb_back #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nntb_pkg::queue_if_t         q_i,
  output logic                        pop_o,
  input  logic                        cfg_we_i,
  input  logic [nntb_pkg::VC_W-1:0]   cfg_data_i,
  output logic                        result_valid_o,
  output nntb_pkg::res_t              result_o
);
  import nntb_pkg::*;

  localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = ((WEIGHT_BITS > TOTAL_W) ? WEIGHT_BITS : TOTAL_W) + 1;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_SCAN     = 2'd1;
  localparam logic [1:0] ST_RET_RD   = 2'd2;
  localparam logic [1:0] ST_RET_WAIT = 2'd3;

  logic [WEIGHT_BITS-1:0]  mem_q [DEPTH];
  logic [WEIGHT_BITS-1:0]  rdata_q;
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           waddr;
  logic                    we;

  logic [1:0]              state_q, state_d;
  logic [VC_W-1:0]         vc_q;
  logic [CW-1:0]           n_q, n_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    cmp_vld_q, cmp_vld_d;
  logic [VW-1:0]           cmp_idx_q, cmp_idx_d;
  logic                    found_q, found_d;
  logic [VW-1:0]           best_q, best_d;
  logic [WEIGHT_BITS-1:0]  best_w_q, best_w_d;
  logic [VW-1:0]           cur_q, cur_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [TOTAL_W-1:0]      total_q, total_d;
  logic                    valid_q, valid_d;
  res_t                    result_q, result_d;

  logic [WEIGHT_BITS-1:0]  add_w;
  logic [SW-1:0]           sum;
  logic [TOTAL_W-1:0]      sat_total;
  logic [CW-1:0]           n_clamped;
  logic                    issue;

  // saturating total update, shared by the step and the return edge
  assign add_w     = (state_q == ST_RET_WAIT) ? rdata_q : best_w_q;
  assign sum       = SW'(total_q) + SW'(add_w);
  assign sat_total = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    if (vc_q < VC_MIN) begin
      n_clamped = CW'(VC_MIN);
    end else if (32'(vc_q) > MAX_VERTICES) begin
      n_clamped = CW'(MAX_VERTICES);
    end else begin
      n_clamped = CW'(vc_q);
    end
  end

  assign waddr = AW'(AW'(VW'(q_i.item.row)) * AW'(MAX_VERTICES) + AW'(VW'(q_i.item.col)));
  assign issue = (state_q == ST_SCAN) && (cnt_q < n_q);

  always_comb begin
    if (state_q == ST_RET_RD) begin
      raddr = AW'(AW'(cur_q) * AW'(MAX_VERTICES));
    end else begin
      raddr = AW'(AW'(cur_q) * AW'(MAX_VERTICES) + AW'(cnt_q));
    end
  end

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    cnt_d     = cnt_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    found_d   = found_q;
    best_d    = best_q;
    best_w_d  = best_w_q;
    cur_d     = cur_q;
    visited_d = visited_q;
    total_d   = total_q;
    valid_d   = 1'b0;
    result_d  = result_q;
    pop_o     = 1'b0;
    we        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          if (q_i.item.op == CMD_RUN) begin
            visited_d             = '0;
            visited_d[0]          = 1'b1;
            total_d               = '0;
            cur_d                 = '0;
            cnt_d                 = '0;
            found_d               = 1'b0;
            n_d                   = n_clamped;
            valid_d               = 1'b1;
            result_d.vertex       = '0;
            result_d.total_cost   = '0;
            result_d.last         = 1'b0;
            state_d               = ST_SCAN;
          end else begin
            we = q_i.item.in_range;
          end
        end
      end

      ST_SCAN: begin
        if (issue) begin
          cnt_d     = cnt_q + CW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = VW'(cnt_q);
        end
        if (cmp_vld_q) begin
          if ((rdata_q != '0) && !visited_q[cmp_idx_q] && (!found_q || rdata_q < best_w_q)) begin
            found_d  = 1'b1;
            best_d   = cmp_idx_q;
            best_w_d = rdata_q;
          end
        end else if (!issue) begin
          // row fully scanned: take the nearest vertex or head home
          if (found_q) begin
            total_d             = sat_total;
            cur_d               = best_q;
            visited_d[best_q]   = 1'b1;
            cnt_d               = '0;
            found_d             = 1'b0;
            valid_d             = 1'b1;
            result_d.vertex     = VERTEX_W'(best_q);
            result_d.total_cost = sat_total;
            result_d.last       = 1'b0;
          end else begin
            state_d = ST_RET_RD;
          end
        end
      end

      ST_RET_RD: begin
        state_d = ST_RET_WAIT;
      end

      ST_RET_WAIT: begin
        total_d             = sat_total;
        cur_d               = '0;
        valid_d             = 1'b1;
        result_d.vertex     = '0;
        result_d.total_cost = sat_total;
        result_d.last       = 1'b1;
        state_d             = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vc_q      <= VC_RESET;
      n_q       <= CW'(VC_MIN);
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      cur_q     <= '0;
      visited_q <= '0;
      total_q   <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        vc_q <= cfg_data_i;
      end
      n_q       <= n_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      cur_q     <= cur_d;
      visited_q <= visited_d;
      total_q   <= total_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    best_q    <= best_d;
    best_w_q  <= best_w_d;
    result_q  <= result_d;
  end

  // cost matrix, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= WEIGHT_BITS'(q_i.item.weight);
    end
    rdata_q <= mem_q[raddr];
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

@@ rtl/core/nearest_neighbor_tour_builder_top.sv @@
// Nearest neighbor tour builder. A load command writes one cost matrix entry and gives no
// result; a run command builds a greedy tour from vertex 0 and gives one result per
// visited vertex plus a final return to vertex 0 with last set. Commands pass through a
// two-entry queue, so loads are taken one per cycle while the back end is free. The run
// is paced by the single read port of the cost matrix: each tour step reads one row of n
// entries, one per cycle, for n vertices in use. Results appear as one-cycle strobes on
// result_valid_o and must be taken when shown. Matrix entries read by a run must have
// been loaded first.
module nearest_neighbor_tour_builder_top #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  nntb_pkg::cmd_t            cmd_i,
  input  logic                      cfg_we_i,
  input  logic [nntb_pkg::VC_W-1:0] cfg_data_i,
  output logic                      result_valid_o,
  output nntb_pkg::res_t            result_o
);
  import nntb_pkg::*;

  queue_if_t q;
  logic      pop;

  nntb_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .pop_i  (pop),
    .q_o    (q)
  );

  nntb_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_i            (q),
    .pop_o          (pop),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

@@ rtl/core/nntb_checker.sv @@
// port-level checks of the tour builder, bound to the top level
`include "assert_macros.svh"

module nntb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           result_valid_o,
  input nntb_pkg::res_t result_o
);
  import nntb_pkg::*;

  // the tour always closes at the start vertex
  `NNTB_ASSERT_NOW(a_last_at_start, clk_i, rst_ni, result_valid_o && result_o.last, result_o.vertex == '0, "final transaction not at vertex 0")

  // vertex 0 before the end is only the opening transaction, with nothing spent yet
  `NNTB_ASSERT_NOW(a_open_zero_total, clk_i, rst_ni, result_valid_o && !result_o.last && result_o.vertex == '0, result_o.total_cost == '0, "opening transaction with nonzero total")

  // two tours cannot finish in adjacent cycles
  `NNTB_ASSERT_NEXT(a_no_double_last, clk_i, rst_ni, result_valid_o && result_o.last, !(result_valid_o && result_o.last), "two final transactions in a row")

  // the queue only fills on an accepted command
  `NNTB_ASSERT_NOW(a_busy_from_accept, clk_i, rst_ni, $rose(busy), $past(start), "busy rose without a command")

endmodule

bind nearest_neighbor_tour_builder_top nntb_checker u_nntb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

@@ dv/tour_checker.sv @@
// tour builder checker: predicts every tour stop and compares the result transactions
module tour_checker #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  nntb_pkg::cmd_t            cmd_i,
  input  logic                      cfg_we_i,
  input  logic [nntb_pkg::VC_W-1:0] cfg_data_i,
  input  logic                      res_valid_i,
  input  nntb_pkg::res_t            res_i,
  output int                        mismatch_count_o,
  output int                        stops_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import nntb_pkg::*;

  localparam logic [WEIGHT_IN_W-1:0] WEIGHT_MASK = (WEIGHT_BITS >= WEIGHT_IN_W) ?
      {WEIGHT_IN_W{1'b1}} : WEIGHT_IN_W'((64'd1 << WEIGHT_BITS) - 1);

  logic [WEIGHT_IN_W-1:0]  cost_mem [MAX_VERTICES][MAX_VERTICES];
  logic [MAX_VERTICES-1:0] seen_mask;
  logic [VERTEX_W-1:0]     here;
  logic [TOTAL_W-1:0]      tour_total;
  logic [VC_W-1:0]         vtx_count;
  res_t                    tour_stops_q[$];
  int                      mismatches = 0;
  int                      pending_stops = 0;

  assign mismatch_count_o = mismatches;
  assign stops_pending_o  = pending_stops;

  task automatic report_mismatch(input string msg);
    $display("%0t tour_checker: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] acc,
                                                 input logic [WEIGHT_IN_W-1:0] w);
    logic [TOTAL_W:0] sum;
    sum = acc + w;
    return (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

  // greedy walk from vertex 0, one expected stop per visited vertex plus the return
  task automatic build_tour();
    int                     n;
    bit                     found;
    logic [VERTEX_W-1:0]    best;
    logic [WEIGHT_IN_W-1:0] best_w;
    logic [WEIGHT_IN_W-1:0] e;
    n = vtx_count;
    if (n < VC_MIN) n = VC_MIN;
    if (n > MAX_VERTICES) n = MAX_VERTICES;
    seen_mask  = '0;
    tour_total = '0;
    here       = '0;
    found      = 1'b1;
    while (found) begin
      seen_mask[here] = 1'b1;
      tour_stops_q.push_back('{vertex: here, total_cost: tour_total, last: 1'b0});
      found  = 1'b0;
      best   = '0;
      best_w = '0;
      for (int i = 0; i < n; i++) begin
        e = cost_mem[here][i];
        // zero is no edge, strict less keeps the lowest index on ties
        if (e != '0 && !seen_mask[i] && (!found || e < best_w)) begin
          found  = 1'b1;
          best_w = e;
          best   = VERTEX_W'(i);
        end
      end
      if (found) begin
        tour_total = sat_add(tour_total, best_w);
        here       = best;
      end
    end
    tour_total = sat_add(tour_total, cost_mem[here][0]);
    here       = '0;
    tour_stops_q.push_back('{vertex: '0, total_cost: tour_total, last: 1'b1});
  endtask

  task automatic check_stop(input res_t got);
    res_t want;
    if (tour_stops_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result: vertex %0d total %0d last %0b",
                                got.vertex, got.total_cost, got.last));
    end else begin
      want = tour_stops_q.pop_front();
      if (got.vertex !== want.vertex)
        report_mismatch($sformatf("vertex: got %0d, want %0d", got.vertex, want.vertex));
      if (got.total_cost !== want.total_cost)
        report_mismatch($sformatf("total_cost at vertex %0d: got %0d, want %0d",
                                  want.vertex, got.total_cost, want.total_cost));
      if (got.last !== want.last)
        report_mismatch($sformatf("last at vertex %0d: got %0b, want %0b",
                                  want.vertex, got.last, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_mask  = '0;
      here       = '0;
      tour_total = '0;
      vtx_count  = VC_RESET;
      tour_stops_q.delete();
    end else begin
      if (res_valid_i) check_stop(res_i);
      if (cfg_we_i) vtx_count = cfg_data_i;
      if (start_i && !busy_i) begin
        if (cmd_i.command == CMD_RUN) begin
          build_tour();
        end else if (cmd_i.row < MAX_VERTICES && cmd_i.col < MAX_VERTICES) begin
          cost_mem[cmd_i.row][cmd_i.col] = cmd_i.weight & WEIGHT_MASK;
        end
      end
    end
    pending_stops = tour_stops_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
// testbench top for the tour builder: clock, reset, command stimulus and the verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nntb_pkg::*;

  localparam int MAX_VERTICES  = 16;
  localparam int RANDOM_ITEMS  = 450;
  localparam int QUIET_TAIL    = 60;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 300;
  localparam int IDLE_LIMIT    = 2000;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  cmd_t            cmd;
  logic            cfg_we;
  logic [VC_W-1:0] cfg_data;
  logic            res_valid;
  res_t            res;
  int              mismatches;
  int              stops_pending;

  int sent = 0;
  int quiet_from = 32'h7fff_ffff;
  int n_used = MAX_VERTICES;
  int idle_cycles = 0;
  bit written [MAX_VERTICES][MAX_VERTICES];

  nearest_neighbor_tour_builder_top #(
    .MAX_VERTICES(MAX_VERTICES),
    .WEIGHT_BITS (16)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .result_valid_o(res_valid),
    .result_o      (res)
  );

  tour_checker #(
    .MAX_VERTICES(MAX_VERTICES),
    .WEIGHT_BITS (16)
  ) tour_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .res_valid_i     (res_valid),
    .res_i           (res),
    .mismatch_count_o(mismatches),
    .stops_pending_o (stops_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // no transaction on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || res_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // zeros and small values give missing edges and ties
  function automatic logic [15:0] pick_weight();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return '0;
    if (sel < 6) return 16'($urandom_range(1, 4));
    if (sel == 6) return 16'hffff;
    return 16'($urandom);
  endfunction

  task automatic issue(input cmd_e op, input logic [3:0] r, input logic [3:0] c,
                       input logic [15:0] w);
    int gap;
    gap = 0;
    if (sent < quiet_from && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= '{command: op, row: r, col: c, weight: w};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == CMD_LOAD) written[r][c] = 1'b1;
    sent++;
  endtask

  task automatic load(input logic [3:0] r, input logic [3:0] c, input logic [15:0] w);
    issue(CMD_LOAD, r, c, w);
  endtask

  task automatic run_tour();
    issue(CMD_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
  endtask

  // a run must never read an entry that was not loaded
  task automatic fill_missing();
    for (int i = 0; i < n_used; i++)
      for (int j = 0; j < n_used; j++)
        if (!written[i][j]) load(4'(i), 4'(j), pick_weight());
  endtask

  task automatic set_vertex_count(input logic [VC_W-1:0] v);
    @(negedge clk);
    start <= 1'b0;
    while (stops_pending != 0) @(negedge clk);
    // loads give no result, let any queued ones drain
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_used = v;
    if (n_used < VC_MIN) n_used = VC_MIN;
    if (n_used > MAX_VERTICES) n_used = MAX_VERTICES;
  endtask

  initial begin
    int phase;
    int kind;
    logic [VC_W-1:0] vc;
    start    = 1'b0;
    cmd      = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    rst_n    = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // two vertices: self loop as return cost, no edge out of vertex 0
    set_vertex_count(VC_W'(2));
    load(4'd0, 4'd0, 16'd5);
    load(4'd0, 4'd1, 16'd0);
    load(4'd1, 4'd0, 16'd0);
    load(4'd1, 4'd1, 16'd7);
    run_tour();
    // largest weights both ways
    load(4'd0, 4'd1, 16'hffff);
    load(4'd1, 4'd0, 16'hffff);
    run_tour();
    // missing return edge
    load(4'd1, 4'd0, 16'd0);
    run_tour();
    // counts below the minimum act as two
    set_vertex_count(VC_W'(0));
    run_tour();
    set_vertex_count(VC_W'(1));
    run_tour();
    // three vertices: tie out of vertex 0 goes to the lower index
    set_vertex_count(VC_W'(3));
    load(4'd0, 4'd1, 16'd4);
    load(4'd0, 4'd2, 16'd4);
    load(4'd0, 4'd0, 16'd1);
    load(4'd1, 4'd0, 16'd9);
    load(4'd1, 4'd2, 16'd3);
    load(4'd2, 4'd0, 16'd2);
    load(4'd2, 4'd1, 16'd1);
    load(4'd2, 4'd2, 16'd0);
    run_tour();
    // dead end at vertex 1, return from there
    load(4'd1, 4'd2, 16'd0);
    run_tour();

    quiet_from = sent + RANDOM_ITEMS - QUIET_TAIL;
    phase = 0;
    while (sent < quiet_from + QUIET_TAIL) begin
      if (phase == 0) vc = VC_W'(16);
      else if (phase == 1) vc = VC_W'(31);
      else if ($urandom_range(0, 9) < 7) vc = VC_W'($urandom_range(0, 6));
      else vc = VC_W'($urandom_range(7, 31));
      set_vertex_count(vc);
      repeat ($urandom_range(2, 6)) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          repeat ($urandom_range(0, n_used))
            load(4'($urandom_range(0, n_used - 1)), 4'($urandom_range(0, n_used - 1)),
                 pick_weight());
          fill_missing();
          run_tour();
        end else if (kind < 9) begin
          repeat ($urandom_range(1, 8))
            load(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), pick_weight());
        end else begin
          fill_missing();
          run_tour();
          run_tour();
        end
      end
      phase++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (stops_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && stops_pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
